@@ sv/assert_macros.svh @@
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) prop) \
        else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif

`endif

@@ sv/cld_pkg.sv @@
package cld_pkg;

    localparam int HDR_W      = 16;
    localparam int BODY_W     = 24;
    localparam int CFG_W      = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int HCNT_W     = HDR_W + 1;
    localparam int LEN_W      = BODY_W + 1;
    localparam int ACC_W      = LEN_W + 4;
    localparam int NAME_LEN   = 14;
    localparam int NIDX_W     = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_HDR  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_BODY = 2'd1;

    localparam logic [HDR_W-1:0]  MAX_HDR_RST  = 16'd8192;
    localparam logic [BODY_W-1:0] MAX_BODY_RST = 24'd8388608;

    localparam logic [1:0] KIND_BODY  = 2'd0;
    localparam logic [1:0] KIND_EMPTY = 2'd1;
    localparam logic [1:0] KIND_OVF   = 2'd2;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UZ    = 8'h5a;
    localparam logic [7:0] CASE_BIT = 8'h20;

    localparam logic [1:0] TM_NONE  = 2'd0;
    localparam logic [1:0] TM_CR    = 2'd1;
    localparam logic [1:0] TM_CRLF  = 2'd2;
    localparam logic [1:0] TM_CRLFCR = 2'd3;

    typedef enum logic [4:0] {
        PH_NAME   = 5'b00001,
        PH_SKIP   = 5'b00010,
        PH_LEAD   = 5'b00100,
        PH_DIGITS = 5'b01000,
        PH_TRAIL  = 5'b10000
    } t_phase;

    typedef struct packed {
        logic [HDR_W-1:0]  max_hdr;
        logic [BODY_W-1:0] max_body;
    } t_cfg;

    typedef struct packed {
        logic       valid;
        logic [1:0] kind;
        logic [7:0] data;
        logic       last;
    } t_result;

    function automatic logic [7:0] hdr_char(input logic [NIDX_W-1:0] idx);
        logic [7:0] c;
        unique case (idx)
            4'd0:    c = "c";
            4'd1:    c = "o";
            4'd2:    c = "n";
            4'd3:    c = "t";
            4'd4:    c = "e";
            4'd5:    c = "n";
            4'd6:    c = "t";
            4'd7:    c = "-";
            4'd8:    c = "l";
            4'd9:    c = "e";
            4'd10:   c = "n";
            4'd11:   c = "g";
            4'd12:   c = "t";
            4'd13:   c = "h";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

@@ sv/cld_cfg_regs.sv @@
module cld_cfg_regs
    import cld_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output t_cfg                 o_cfg
);

    logic [HDR_W-1:0]  r_max_hdr;
    logic [BODY_W-1:0] r_max_body;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_hdr  <= MAX_HDR_RST;
            r_max_body <= MAX_BODY_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_MAX_HDR) begin
                r_max_hdr <= i_cfg_data[HDR_W-1:0];
            end
            if (i_cfg_idx == CFG_MAX_BODY) begin
                r_max_body <= i_cfg_data[BODY_W-1:0];
            end
        end
    end

    assign o_cfg.max_hdr  = r_max_hdr;
    assign o_cfg.max_body = r_max_body;

endmodule

@@ sv/cld_core.sv @@
`include "assert_macros.svh"

module cld_core
    import cld_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_fire,
    input  logic [7:0] i_byte,
    input  t_cfg       i_cfg,
    output t_result    o_res
);

    logic              r_overflow, n_overflow;
    logic              r_in_body, n_in_body;
    logic [BODY_W-1:0] r_rem, n_rem;
    logic [HCNT_W-1:0] r_hc, n_hc;
    logic [1:0]        r_tm, n_tm;
    logic [NIDX_W-1:0] r_idx, n_idx;
    t_phase            r_phase, n_phase;
    logic              r_decided, n_decided;
    logic              r_ok, n_ok;
    logic [LEN_W-1:0]  r_len, n_len;

    logic              w_blank, w_digit, w_cr, w_lf, w_prev_cr, w_done;
    logic [7:0]        w_lc;
    logic [ACC_W-1:0]  w_acc;
    t_result           w_res;

    assign w_blank = (i_byte == CH_SP) || (i_byte == CH_TAB);
    assign w_digit = (i_byte >= CH_0) && (i_byte <= CH_9);
    assign w_cr    = (i_byte == CH_CR);
    assign w_lf    = (i_byte == CH_LF);
    assign w_lc    = ((i_byte >= CH_UA) && (i_byte <= CH_UZ)) ? (i_byte | CASE_BIT) : i_byte;
    assign w_prev_cr = (r_tm == TM_CR) || (r_tm == TM_CRLFCR);
    assign w_acc   = {1'b0, r_len, 3'b000} + {3'b000, r_len, 1'b0}
                   + {{(ACC_W-4){1'b0}}, i_byte[3:0]};

    always_comb begin
        n_overflow = r_overflow;
        n_in_body  = r_in_body;
        n_rem      = r_rem;
        n_hc       = r_hc;
        n_tm       = r_tm;
        n_idx      = r_idx;
        n_phase    = r_phase;
        n_decided  = r_decided;
        n_ok       = r_ok;
        n_len      = r_len;
        w_done     = 1'b0;
        w_res      = '0;

        if (!r_overflow) begin
            if (r_in_body) begin
                n_rem      = r_rem - 1'b1;
                w_res.valid = 1'b1;
                w_res.kind  = KIND_BODY;
                w_res.data  = i_byte;
                w_res.last  = (n_rem == '0);
                if (n_rem == '0) begin
                    n_in_body = 1'b0;
                end
            end else begin
                n_hc = r_hc + 1'b1;

                if (!r_decided) begin
                    unique case (r_phase)
                        PH_NAME: begin
                            if ((r_idx < NIDX_W'(NAME_LEN)) && (w_lc == hdr_char(r_idx))) begin
                                n_idx = r_idx + 1'b1;
                            end else if ((i_byte == CH_COLON) &&
                                         (r_idx == NIDX_W'(NAME_LEN))) begin
                                n_phase = PH_LEAD;
                            end else begin
                                n_phase = PH_SKIP;
                            end
                        end
                        PH_LEAD: begin
                            if (w_digit) begin
                                n_len   = {{(LEN_W-4){1'b0}}, i_byte[3:0]};
                                n_phase = PH_DIGITS;
                            end else if (!w_blank) begin
                                n_decided = 1'b1;
                                n_ok      = 1'b0;
                                n_phase   = PH_SKIP;
                            end
                        end
                        PH_DIGITS: begin
                            if (w_digit) begin
                                if (w_acc > {{(ACC_W-BODY_W){1'b0}}, i_cfg.max_body}) begin
                                    n_len = {1'b0, i_cfg.max_body} + 1'b1;
                                end else begin
                                    n_len = w_acc[LEN_W-1:0];
                                end
                            end else if (w_blank || w_cr) begin
                                n_phase = PH_TRAIL;
                            end else begin
                                n_decided = 1'b1;
                                n_ok      = 1'b0;
                                n_phase   = PH_SKIP;
                            end
                        end
                        PH_TRAIL: begin
                            if (w_lf && w_prev_cr) begin
                                n_decided = 1'b1;
                                n_ok      = 1'b1;
                            end else if (!(w_blank || w_cr)) begin
                                n_decided = 1'b1;
                                n_ok      = 1'b0;
                                n_phase   = PH_SKIP;
                            end
                        end
                        PH_SKIP: begin
                        end
                        default: begin
                            n_phase = PH_SKIP;
                        end
                    endcase
                end

                if (w_lf && w_prev_cr) begin
                    n_phase = PH_NAME;
                    n_idx   = '0;
                end

                if (w_cr) begin
                    n_tm = (r_tm == TM_CRLF) ? TM_CRLFCR : TM_CR;
                end else if (w_lf) begin
                    if (r_tm == TM_CR) begin
                        n_tm = TM_CRLF;
                    end else if (r_tm == TM_CRLFCR) begin
                        w_done = 1'b1;
                    end else begin
                        n_tm = TM_NONE;
                    end
                end else begin
                    n_tm = TM_NONE;
                end

                if (n_hc > {1'b0, i_cfg.max_hdr}) begin
                    n_overflow = 1'b1;
                    w_res.valid = 1'b1;
                    w_res.kind  = KIND_OVF;
                end else if (w_done) begin
                    if (n_decided && n_ok) begin
                        if (n_len > {1'b0, i_cfg.max_body}) begin
                            n_overflow = 1'b1;
                            w_res.valid = 1'b1;
                            w_res.kind  = KIND_OVF;
                        end else if (n_len == '0) begin
                            w_res.valid = 1'b1;
                            w_res.kind  = KIND_EMPTY;
                            w_res.last  = 1'b1;
                        end else begin
                            n_in_body = 1'b1;
                            n_rem     = n_len[BODY_W-1:0];
                        end
                    end
                end

                if (n_overflow || w_done) begin
                    n_hc      = '0;
                    n_tm      = TM_NONE;
                    n_idx     = '0;
                    n_phase   = PH_NAME;
                    n_decided = 1'b0;
                    n_ok      = 1'b0;
                    n_len     = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_overflow <= 1'b0;
            r_in_body  <= 1'b0;
            r_rem      <= '0;
            r_hc       <= '0;
            r_tm       <= TM_NONE;
            r_idx      <= '0;
            r_phase    <= PH_NAME;
            r_decided  <= 1'b0;
            r_ok       <= 1'b0;
            r_len      <= '0;
        end else if (i_fire) begin
            r_overflow <= n_overflow;
            r_in_body  <= n_in_body;
            r_rem      <= n_rem;
            r_hc       <= n_hc;
            r_tm       <= n_tm;
            r_idx      <= n_idx;
            r_phase    <= n_phase;
            r_decided  <= n_decided;
            r_ok       <= n_ok;
            r_len      <= n_len;
        end
    end

    assign o_res = w_res;

    `ASSERT_NEVER(a_body_and_overflow, i_clk, i_rst_n, r_in_body && r_overflow)
    `ASSERT_NEVER(a_body_zero_rem, i_clk, i_rst_n, r_in_body && (r_rem == '0))
    `ASSERT_CLK(a_ovf_sticky, i_clk, i_rst_n, r_overflow |=> r_overflow)

endmodule

@@ sv/content_length_deframer_unit.sv @@
// Content-Length deframer: takes one stream byte per transfer and returns the
// message bodies framed by CR LF CR LF header blocks with a content-length
// line. Each body byte leaves as one transfer (tuser kind body, tlast on its
// final byte); a zero length gives one empty-message transfer with tlast set.
// A header block longer than max_header_bytes or a length above
// max_body_bytes gives one overflow transfer, after which all input is
// consumed without output until reset. Throughput is one byte per clock when
// the output is not stalled by m_axis_tready; each byte is parsed between the
// input register and the output register by combinational logic.
// Write the limits only while the block is idle.
`include "assert_macros.svh"

module content_length_deframer_unit
    import cld_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [7:0]           i_s_axis_tdata,   // byte_in
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [7:0]           o_m_axis_tdata,   // data
    output logic [1:0]           o_m_axis_tuser,   // kind
    output logic                 o_m_axis_tlast
);

    t_cfg       w_cfg;
    t_result    w_res;
    logic       w_fire;
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    logic [7:0] r_out_data;
    logic [1:0] r_out_kind;
    logic       r_out_last;

    cld_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    cld_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_fire),
        .i_byte  (r_in_byte),
        .i_cfg   (w_cfg),
        .o_res   (w_res)
    );

    assign w_fire          = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || w_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_byte <= i_s_axis_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= w_res.valid;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_data <= w_res.data;
            r_out_kind <= w_res.kind;
            r_out_last <= w_res.last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_kind;
    assign o_m_axis_tlast  = r_out_last;

    `ASSERT_CLK(a_in_hold, i_clk, i_rst_n,
        (r_in_valid && !w_fire) |=> (r_in_valid && $stable(r_in_byte)))
    `ASSERT_CLK(a_nonbody_zero, i_clk, i_rst_n,
        (r_out_valid && (r_out_kind != KIND_BODY)) |-> (r_out_data == 8'h00))
    `ASSERT_CLK(a_empty_last, i_clk, i_rst_n,
        (r_out_valid && (r_out_kind == KIND_EMPTY)) |-> r_out_last)
    `ASSERT_CLK(a_ovf_final, i_clk, i_rst_n,
        (r_out_valid && i_m_axis_tready && (r_out_kind == KIND_OVF)) |=> !r_out_valid)

endmodule
